FILE: design/pbmu_pkg.sv
// Package for the premultiplied blend mode unit.
// Holds blend mode codes, value widths and the divide-by-65535 helper.
// No dependencies.
package pbmu_pkg;

  localparam int unsigned ChanW = 16;
  localparam int unsigned ProdW = 32;
  localparam int unsigned ModeW = 5;
  localparam int unsigned WideW = 20;
  localparam int unsigned GrayW = 17;
  localparam int unsigned NumLanes = 4;
  localparam int unsigned AlphaLane = 3;

  localparam logic [ChanW-1:0] HalfLevel = 16'd32767;
  localparam logic [14:0] GrayCoefR = 15'd9798;
  localparam logic [14:0] GrayCoefG = 15'd19234;
  localparam logic [14:0] GrayCoefB = 15'd3736;
  localparam int unsigned GrayShift = 15;

  localparam logic [ModeW-1:0] ModeNormal       = 5'd0;
  localparam logic [ModeW-1:0] ModeMultiply     = 5'd1;
  localparam logic [ModeW-1:0] ModeDarken       = 5'd2;
  localparam logic [ModeW-1:0] ModeLinearBurn   = 5'd3;
  localparam logic [ModeW-1:0] ModeDarkerColor  = 5'd4;
  localparam logic [ModeW-1:0] ModeScreen       = 5'd5;
  localparam logic [ModeW-1:0] ModeLighten      = 5'd6;
  localparam logic [ModeW-1:0] ModeLinearDodge  = 5'd7;
  localparam logic [ModeW-1:0] ModeLighterColor = 5'd8;
  localparam logic [ModeW-1:0] ModeOverlay      = 5'd9;
  localparam logic [ModeW-1:0] ModeHardLight    = 5'd10;
  localparam logic [ModeW-1:0] ModeLinearLight  = 5'd11;
  localparam logic [ModeW-1:0] ModePinLight     = 5'd12;
  localparam logic [ModeW-1:0] ModeHardMix      = 5'd13;
  localparam logic [ModeW-1:0] ModeDifference   = 5'd14;
  localparam logic [ModeW-1:0] ModeExclusion    = 5'd15;
  localparam logic [ModeW-1:0] ModeSubtract     = 5'd16;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic signed [WideW-1:0] wide_t;

  // Round a 16x16 product to nearest over 65535
  function automatic chan_t div65535(input logic [ProdW-1:0] p);
    logic [ProdW:0] x;
    logic [ProdW:0] t;
    x = {1'b0, p} + (ProdW+1)'(HalfLevel);
    t = x + (ProdW+1)'(x[ProdW:16]) + (ProdW+1)'(1);
    return t[ProdW-1:16];
  endfunction

endpackage

FILE: design/pbmu_lane.sv
// One color lane of the blend unit: products, rounding and per-mode value.
// Depends on pbmu_pkg.
module pbmu_lane import pbmu_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [ModeW-1:0] mode,
  input  chan_t            s,
  input  chan_t            d,
  input  chan_t            sa,
  input  chan_t            da,
  input  chan_t            alpha2,
  output chan_t            s2,
  output chan_t            d2,
  output chan_t            p2,
  output chan_t            s3,
  output chan_t            d3,
  output wide_t            r3
);

  logic [ProdW-1:0] ps1, pd1, pp1;
  wide_t            r_next;
  wide_t            ws, wd, wp, wa;

  // Stage 1: raw products
  always_ff @(posedge clk) begin
    if (en) begin
      ps1 <= ProdW'(s) * ProdW'(da);
      pd1 <= ProdW'(d) * ProdW'(sa);
      pp1 <= ProdW'(s) * ProdW'(d);
    end
  end

  // Stage 2: round to nearest over full scale
  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= div65535(ps1);
      d2 <= div65535(pd1);
      p2 <= div65535(pp1);
    end
  end

  assign ws = WideW'(s2);
  assign wd = WideW'(d2);
  assign wp = WideW'(p2);
  assign wa = WideW'(alpha2);

  // Select the mode formula
  always_comb begin
    case (mode)
      ModeMultiply:    r_next = wp;
      ModeDarken:      r_next = (ws < wd) ? ws : wd;
      ModeLinearBurn:  r_next = ws + wd - wa;
      ModeScreen:      r_next = ws + wd - wp;
      ModeLighten:     r_next = (ws > wd) ? ws : wd;
      ModeLinearDodge: r_next = (ws + wd < wa) ? ws + wd : wa;
      ModeOverlay: begin
        if (wd < (wa >>> 1)) r_next = wp <<< 1;
        else r_next = wa - ((wa + wp - ws - wd) <<< 1);
      end
      ModeHardLight: begin
        if (ws < (wa >>> 1)) r_next = wp <<< 1;
        else r_next = wa - ((wa + wp - ws - wd) <<< 1);
      end
      ModeLinearLight: begin
        if ((ws <<< 1) + wd - wa < wa) r_next = (ws <<< 1) + wd - wa;
        else r_next = wa;
      end
      ModePinLight: begin
        if (s2 > HalfLevel) begin
          if (((ws - WideW'(HalfLevel)) <<< 1) > wd) r_next = (ws - WideW'(HalfLevel)) <<< 1;
          else r_next = wd;
        end else begin
          if ((ws <<< 1) < wd) r_next = ws <<< 1;
          else r_next = wd;
        end
      end
      ModeHardMix:    r_next = (ws + wd > wa) ? wa : '0;
      ModeDifference: r_next = (ws > wd) ? ws - wd : wd - ws;
      ModeExclusion:  r_next = ws + wd - (wp <<< 1);
      ModeSubtract:   r_next = wd - ws;
      default:        r_next = ws;
    endcase
  end

  // Stage 3: hold lane value and the scaled inputs for the merge
  always_ff @(posedge clk) begin
    if (en) begin
      r3 <= r_next;
      s3 <= s2;
      d3 <= d2;
    end
  end

endmodule

FILE: design/pbmu_merge.sv
// Merge stage: gray compare for the color modes, alpha override, saturation.
// Depends on pbmu_pkg.
module pbmu_merge import pbmu_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [ModeW-1:0] mode,
  input  chan_t            s2_r, s2_g, s2_b,
  input  chan_t            d2_r, d2_g, d2_b,
  input  chan_t            alpha3,
  input  chan_t            s3 [NumLanes],
  input  chan_t            d3 [NumLanes],
  input  wide_t            r3 [NumLanes],
  output chan_t            res [NumLanes]
);

  logic [GrayW-1:0] gray_s, gray_d;
  logic [GrayW-1:0] gray_s_next, gray_d_next;
  logic [ProdW:0]   sum_s, sum_d;
  chan_t            alpha_q;
  logic             pick_src;
  chan_t            res_next [NumLanes];

  // Stage 3: gray of the scaled source and destination
  always_comb begin
    sum_s = (ProdW+1)'(GrayCoefR) * (ProdW+1)'(s2_r)
          + (ProdW+1)'(GrayCoefG) * (ProdW+1)'(s2_g)
          + (ProdW+1)'(GrayCoefB) * (ProdW+1)'(s2_b);
    sum_d = (ProdW+1)'(GrayCoefR) * (ProdW+1)'(d2_r)
          + (ProdW+1)'(GrayCoefG) * (ProdW+1)'(d2_g)
          + (ProdW+1)'(GrayCoefB) * (ProdW+1)'(d2_b);
    gray_s_next = GrayW'(sum_s >> GrayShift);
    gray_d_next = GrayW'(sum_d >> GrayShift);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gray_s <= gray_s_next;
      gray_d <= gray_d_next;
    end
  end

  assign alpha_q = alpha3;

  // Pick, override and saturate each lane
  always_comb begin
    pick_src = 1'b0;
    if (mode == ModeDarkerColor) pick_src = gray_s < gray_d;
    else if (mode == ModeLighterColor) pick_src = gray_s > gray_d;
    for (int i = 0; i < NumLanes; i++) begin
      if (mode == ModeDarkerColor || mode == ModeLighterColor) begin
        res_next[i] = pick_src ? s3[i] : d3[i];
      end else if (i == AlphaLane && (mode == ModeDifference ||
                   mode == ModeExclusion || mode == ModeSubtract)) begin
        res_next[i] = alpha_q;
      end else if (r3[i] < 0) begin
        res_next[i] = '0;
      end else if (r3[i] > WideW'(16'hFFFF)) begin
        res_next[i] = '1;
      end else begin
        res_next[i] = r3[i][ChanW-1:0];
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (en) res <= res_next;
  end

endmodule

FILE: design/premultiplied_blend_mode_unit_core.sv
// Top level of the premultiplied blend mode unit.
// Depends on pbmu_pkg, pbmu_lane and pbmu_merge.
//
// Takes one source/destination pixel pair per clock while not stalled and returns
// one blended premultiplied pixel through the product, rounding, mode and gray,
// and merge/output stages. Four lanes run the same products and mode formula
// on R, G, B and A; the A lane's source-times-destination product is the
// blended alpha shared by all lanes. The whole pipeline advances together and
// holds while the output word is stalled, so one word per clock is sustained
// when the receiver keeps up. blend_mode is written via cfg_we/cfg_wdata and
// must only change while no word is in flight.
module premultiplied_blend_mode_unit_core import pbmu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [ModeW-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  chan_t            src_red,
  input  chan_t            src_green,
  input  chan_t            src_blue,
  input  chan_t            src_alpha,
  input  chan_t            dst_red,
  input  chan_t            dst_green,
  input  chan_t            dst_blue,
  input  chan_t            dst_alpha,
  output logic             out_valid,
  input  logic             out_stall,
  output chan_t            out_red,
  output chan_t            out_green,
  output chan_t            out_blue,
  output chan_t            out_alpha
);

  logic [ModeW-1:0] blend_mode;
  logic             en;
  logic             v1, v2, v3;
  chan_t            s_in [NumLanes];
  chan_t            d_in [NumLanes];
  chan_t            s2 [NumLanes];
  chan_t            d2 [NumLanes];
  chan_t            p2 [NumLanes];
  chan_t            s3 [NumLanes];
  chan_t            d3 [NumLanes];
  wide_t            r3 [NumLanes];
  chan_t            res [NumLanes];
  chan_t            alpha3;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) blend_mode <= ModeNormal;
    else if (cfg_we) blend_mode <= cfg_wdata;
  end

  // Advance unless a finished word is stalled
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  assign s_in[0] = src_red;
  assign s_in[1] = src_green;
  assign s_in[2] = src_blue;
  assign s_in[3] = src_alpha;
  assign d_in[0] = dst_red;
  assign d_in[1] = dst_green;
  assign d_in[2] = dst_blue;
  assign d_in[3] = dst_alpha;

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    pbmu_lane u_lane (
      .clk    (clk),
      .en     (en),
      .mode   (blend_mode),
      .s      (s_in[g]),
      .d      (d_in[g]),
      .sa     (src_alpha),
      .da     (dst_alpha),
      .alpha2 (p2[AlphaLane]),
      .s2     (s2[g]),
      .d2     (d2[g]),
      .p2     (p2[g]),
      .s3     (s3[g]),
      .d3     (d3[g]),
      .r3     (r3[g])
    );
  end

  // Hold alpha alongside stage 3
  always_ff @(posedge clk) begin
    if (en) alpha3 <= p2[AlphaLane];
  end

  pbmu_merge u_merge (
    .clk    (clk),
    .en     (en),
    .mode   (blend_mode),
    .s2_r   (s2[0]),
    .s2_g   (s2[1]),
    .s2_b   (s2[2]),
    .d2_r   (d2[0]),
    .d2_g   (d2[1]),
    .d2_b   (d2[2]),
    .alpha3 (alpha3),
    .s3     (s3),
    .d3     (d3),
    .r3     (r3),
    .res    (res)
  );

  assign out_red   = res[0];
  assign out_green = res[1];
  assign out_blue  = res[2];
  assign out_alpha = res[3];

endmodule

FILE: design/pbmu_checker.sv
// Port-level checker for the premultiplied blend mode unit, with its bind.
// Depends on pbmu_pkg.
module pbmu_checker import pbmu_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  in_stall,
  input logic  out_valid,
  input logic  out_stall,
  input chan_t out_red,
  input chan_t out_alpha
);

  // A stalled output word stays
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped under stall");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_alpha))
    else $error("stalled output word changed");

  // Input stalls only behind a stalled output word
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  // Reset empties the pipeline
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind premultiplied_blend_mode_unit_core pbmu_checker u_pbmu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_red   (out_red),
  .out_alpha (out_alpha)
);

FILE: tb/tb_premultiplied_blend_mode_unit_core.sv
// Testbench for premultiplied_blend_mode_unit_core: random and directed pixel pairs
// in every blend mode, checked against an in-bench blend predictor.
// Depends on pbmu_pkg and the RTL of the blend unit.
module tb_premultiplied_blend_mode_unit_core;
  import pbmu_pkg::*;

  typedef struct packed {
    chan_t r, g, b, a;
  } pixel_t;

  // Blend predictor and queue of expected pixels
  class blend_scoreboard;
    pixel_t expected_q[$];
    logic [ModeW-1:0] mode;
    int mismatches;

    function longint rmul(longint a, longint b);
      return (a * b + 32767) / 65535;
    endfunction

    function longint gray(longint c[4]);
      return (9798 * c[0] + 19234 * c[1] + 3736 * c[2]) >>> 15;
    endfunction

    function chan_t clamp(longint v);
      if (v < 0) return 16'd0;
      if (v > 65535) return 16'hffff;
      return v[15:0];
    endfunction

    function void note_input(pixel_t sp, pixel_t dp);
      longint s[4], d[4], sv[4], dv[4], pv[4], al, v, key;
      bit pick;
      pixel_t o;
      chan_t lanes[4];
      s = '{sp.r, sp.g, sp.b, sp.a};
      d = '{dp.r, dp.g, dp.b, dp.a};
      al = rmul(s[3], d[3]);
      for (int i = 0; i < 4; i++) begin
        sv[i] = rmul(s[i], d[3]);
        dv[i] = rmul(d[i], s[3]);
        pv[i] = rmul(s[i], d[i]);
      end
      pick = (mode == ModeDarkerColor) ? gray(sv) < gray(dv) :
             (mode == ModeLighterColor) ? gray(sv) > gray(dv) : 1'b0;
      for (int i = 0; i < 4; i++) begin
        case (mode)
          ModeMultiply: v = pv[i];
          ModeDarken: v = sv[i] < dv[i] ? sv[i] : dv[i];
          ModeLinearBurn: v = sv[i] + dv[i] - al;
          ModeDarkerColor, ModeLighterColor: v = pick ? sv[i] : dv[i];
          ModeScreen: v = sv[i] + dv[i] - pv[i];
          ModeLighten: v = sv[i] > dv[i] ? sv[i] : dv[i];
          ModeLinearDodge: v = (sv[i] + dv[i] < al) ? sv[i] + dv[i] : al;
          ModeOverlay, ModeHardLight: begin
            key = (mode == ModeOverlay) ? dv[i] : sv[i];
            v = (key < (al >>> 1)) ? 2 * pv[i] : al - 2 * (al + pv[i] - sv[i] - dv[i]);
          end
          ModeLinearLight: begin
            v = 2 * sv[i] + dv[i] - al;
            if (v > al) v = al;
          end
          ModePinLight: begin
            if (sv[i] > 32767) begin
              v = 2 * (sv[i] - 32767);
              if (dv[i] > v) v = dv[i];
            end else begin
              v = 2 * sv[i];
              if (dv[i] < v) v = dv[i];
            end
          end
          ModeHardMix: v = (sv[i] + dv[i] > al) ? al : 0;
          ModeDifference: v = sv[i] > dv[i] ? sv[i] - dv[i] : dv[i] - sv[i];
          ModeExclusion: v = sv[i] + dv[i] - 2 * pv[i];
          ModeSubtract: v = dv[i] - sv[i];
          default: v = sv[i];
        endcase
        if (i == 3 && mode >= ModeDifference && mode <= ModeSubtract) v = al;
        lanes[i] = clamp(v);
      end
      o = '{lanes[0], lanes[1], lanes[2], lanes[3]};
      expected_q.push_back(o);
    endfunction

    function void check_result(pixel_t got);
      pixel_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
        return;
      end
      want = expected_q.pop_front();
      if (want.r !== got.r || want.g !== got.g || want.b !== got.b || want.a !== got.a) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch mode %0d: expected %h actual %h", mode, want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [ModeW-1:0] cfg_wdata = '0;
  logic in_valid = 0;
  logic in_stall;
  chan_t src_red = 0, src_green = 0, src_blue = 0, src_alpha = 0;
  chan_t dst_red = 0, dst_green = 0, dst_blue = 0, dst_alpha = 0;
  logic out_valid;
  logic out_stall = 0;
  chan_t out_red, out_green, out_blue, out_alpha;

  blend_scoreboard blend_sb = new();
  int cycle_count = 0;
  bit sink_busy = 0;

  always #5 clk = ~clk;

  premultiplied_blend_mode_unit_core dut (.*);

  // Count cycles and give up at the limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("FAIL premultiplied_blend_mode_unit_core");
      $finish;
    end
  end

  // Check accepted words and randomize stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      blend_sb.check_result('{out_red, out_green, out_blue, out_alpha});
    if (rst) out_stall <= 0;
    else if (!sink_busy) out_stall <= 0;
    else if ($urandom_range(0, 9) < 3) out_stall <= 1;
    else if ($urandom_range(0, 99) < 3) out_stall <= 1;
    else out_stall <= 0;
  end

  // Stall pattern: busy stretches alternate with free-running ones
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) sink_busy <= ~sink_busy;
  end

  function automatic chan_t pick_chan();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return chan_t'(16'h7fff + $urandom_range(0, 2) - 1);
      default: return chan_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic write_mode(input logic [ModeW-1:0] m);
    cfg_we <= 1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 0;
    blend_sb.mode = m;
  endtask

  // Send one pixel pair, hold until accepted, then maybe idle
  task automatic send_pixel(input pixel_t sp, input pixel_t dp);
    int gap;
    in_valid <= 1;
    {src_red, src_green, src_blue, src_alpha} <= sp;
    {dst_red, dst_green, dst_blue, dst_alpha} <= dp;
    do @(posedge clk); while (in_stall);
    blend_sb.note_input(sp, dp);
    gap = ($urandom_range(0, 1) == 0) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (blend_sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p = '{pick_chan(), pick_chan(), pick_chan(), pick_chan()};
    return p;
  endfunction

  initial begin
    pixel_t sp, dp;
    logic [ModeW-1:0] m;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes in a few modes, including an out-of-range code
    for (int k = 0; k < 6; k++) begin
      m = (k == 0) ? ModeNormal : (k == 1) ? ModeSubtract : (k == 2) ? 5'd31 :
          (k == 3) ? ModePinLight : (k == 4) ? ModeLinearBurn : ModeOverlay;
      write_mode(m);
      send_pixel('{16'hffff, 16'hffff, 16'hffff, 16'hffff},
                 '{16'h0000, 16'h0000, 16'h0000, 16'h0000});
      send_pixel('{16'h0000, 16'h0000, 16'h0000, 16'h0000},
                 '{16'hffff, 16'hffff, 16'hffff, 16'hffff});
      send_pixel('{16'hffff, 16'h8000, 16'h7fff, 16'hffff},
                 '{16'hffff, 16'h7fff, 16'h8000, 16'hffff});
      drain();
    end

    // Random phases across every mode, then random codes from the whole range
    for (int ph = 0; ph < 27; ph++) begin
      m = (ph < 17) ? ph[4:0] : ModeW'($urandom_range(0, 31));
      write_mode(m);
      for (int n = 0; n < 50; n++) begin
        sp = rand_pixel();
        dp = rand_pixel();
        send_pixel(sp, dp);
        // Hold off until everything in flight has come back
        if (n == 25 && ph == 3) begin
          in_valid <= 0;
          while (blend_sb.expected_q.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (blend_sb.mismatches == 0 && blend_sb.expected_q.size() == 0) begin
      $display("PASS premultiplied_blend_mode_unit_core");
    end else begin
      $display("FAIL premultiplied_blend_mode_unit_core");
    end
    $finish;
  end
endmodule
